### src/lsmc_pkg.sv
package lsmc_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 4;
	localparam int BLOCK_W   = 3;
	localparam int PAT_BYTES = 8;
	localparam int PAT_W     = PAT_BYTES * BYTE_W;
	localparam int LINE_W    = 16;
	localparam int TOTAL_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

### src/lsmc_cell.sv
module lsmc_cell
	import lsmc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  byte_t     byte_in,
	input  logic      valid_in,
	input  byte_t     want,
	input  logic      used,
	output byte_t     byte_q,
	output logic      valid_q,
	output logic      ok
);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= valid_in;
		end
	end

	// judge the byte this cell holds after the shift
	assign ok = !used || (valid_in && (byte_in == want));

endmodule

### src/line_substring_match_counter_core.sv
// Line substring match counter.
// Text enters one transaction per cycle on the input channel (in_valid/in_ready):
// char_byte is a character of the current line, or line_end=1 closes the line.
// Each closed line yields one transaction on the output channel (out_valid/out_ready)
// carrying line_number, line_matched, line_count and total_count.
// The pattern (cfg index 0, 64 bits, first byte lowest) and its length (cfg index 1,
// 1..MAX_PATTERN) are written on the cfg channel, which is always ready.
// Characters are absorbed at one per cycle by a chain of MAX_PATTERN byte cells that
// compare against the pattern in parallel; a match is counted in the cycle the
// character is accepted. A line result appears on the output register in the cycle after
// its line_end is accepted. Throughput is one transaction per cycle.
// When the receiver stalls, characters are still taken; a further line_end waits
// while a result is held and not taken.
// Reset clears the line state, sets line numbering to 1, pattern to zero and length
// to 1; no clearing pass is needed.
module line_substring_match_counter_core
	import lsmc_pkg::*;
#(
	parameter int MAX_PATTERN = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    char_byte,
	input  logic                 line_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [LINE_W-1:0]    line_number,
	output logic                 line_matched,
	output logic [LINE_W-1:0]    line_count,
	output logic [TOTAL_W-1:0]   total_count,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data
);

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

	logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_q;
	logic [LEN_W-1:0]   length_q;
	logic [BLOCK_W-1:0] block_q;
	logic [LINE_W-1:0]  hits_q;
	logic [LINE_W-1:0]  index_q;
	logic [TOTAL_W-1:0] total_q;

	logic [LEN_W-1:0] eff_len;
	logic             take;
	logic             take_char;
	logic             take_end;
	cell_ctl_t        ctl;

	byte_t [MAX_PATTERN-1:0] cell_byte;
	logic  [MAX_PATTERN-1:0] cell_valid;
	logic  [MAX_PATTERN-1:0] cell_ok;
	logic                    hit;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready || !line_end;
	assign take      = in_valid && in_ready;
	assign take_char = take && !line_end;
	assign take_end  = take && line_end;
	assign ctl       = '{shift: take_char, clear: take_end};

	always_comb begin
		if (length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (length_q > MAX_LEN) begin
			eff_len = MAX_LEN;
		end else begin
			eff_len = length_q;
		end
	end

	for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
		logic [LEN_W-1:0] sel;
		byte_t            in_byte;
		logic             in_valid_bit;

		assign sel = eff_len - LEN_W'(1) - LEN_W'(p);

		if (p == 0) begin : g_head
			assign in_byte      = char_byte;
			assign in_valid_bit = 1'b1;
		end else begin : g_link
			assign in_byte      = cell_byte[p-1];
			assign in_valid_bit = cell_valid[p-1];
		end

		lsmc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.byte_in  (in_byte),
			.valid_in (in_valid_bit),
			.want     (pattern_q[sel[BLOCK_W-1:0]]),
			.used     (LEN_W'(p) < eff_len),
			.byte_q   (cell_byte[p]),
			.valid_q  (cell_valid[p]),
			.ok       (cell_ok[p])
		);
	end

	assign hit = &cell_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PATTERN: pattern_q <= cfg_data;
				CFG_LENGTH:  length_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= '0;
			hits_q  <= '0;
			index_q <= LINE_W'(1);
			total_q <= '0;
		end else if (take_end) begin
			block_q <= '0;
			hits_q  <= '0;
			if (index_q != '1) begin
				index_q <= index_q + LINE_W'(1);
			end
		end else if (take_char) begin
			if (block_q != '0) begin
				block_q <= block_q - BLOCK_W'(1);
			end else if (hit) begin
				if (hits_q != '1) begin
					hits_q <= hits_q + LINE_W'(1);
				end
				if (total_q != '1) begin
					total_q <= total_q + TOTAL_W'(1);
				end
				block_q <= BLOCK_W'(eff_len - LEN_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take_end) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_end) begin
			line_number  <= index_q;
			line_matched <= (hits_q != '0);
			line_count   <= hits_q;
			total_count  <= total_q;
		end
	end

endmodule

### verif/line_substring_match_counter_core_tb.sv
module line_substring_match_counter_core_tb
	import lsmc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN      = 8;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic [LINE_W-1:0]  number;
		logic               matched;
		logic [LINE_W-1:0]  count;
		logic [TOTAL_W-1:0] total;
	} line_result_t;

	class line_score;
		logic [PAT_W-1:0]   pattern;
		logic [LEN_W-1:0]   length;
		byte_t              window[PAT_BYTES];
		int                 seen;
		int                 blocked;
		logic [LINE_W-1:0]  hits;
		logic [LINE_W-1:0]  line_no;
		logic [TOTAL_W-1:0] total;
		line_result_t       due[$];
		int                 errors;

		function void clear();
			pattern = '0;
			length  = 1;
			foreach (window[i]) window[i] = '0;
			seen    = 0;
			blocked = 0;
			hits    = '0;
			line_no = 1;
			total   = '0;
			due.delete();
			errors  = 0;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] data);
			if (idx == CFG_PATTERN) begin
				pattern = data;
			end else if (idx == CFG_LENGTH) begin
				length = data[LEN_W-1:0];
			end
		endfunction

		function int span();
			int n;
			n = length;
			if (n < 1) n = 1;
			if (n > MAX_LEN) n = MAX_LEN;
			return n;
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void take(byte_t c, logic e);
			int           n;
			bit           found;
			line_result_t r;
			n = span();
			if (e) begin
				r = '{line_no, hits != 0, hits, total};
				due.push_back(r);
				if (line_no != '1) line_no++;
				hits    = '0;
				seen    = 0;
				blocked = 0;
				foreach (window[i]) window[i] = '0;
				return;
			end
			for (int i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
			window[0] = c;
			if (seen < MAX_LEN) seen++;
			if (blocked > 0) begin
				blocked--;
			end else if (seen >= n) begin
				found = 1;
				for (int i = 0; i < n; i++) begin
					if (window[n-1-i] != pattern[BYTE_W*i +: BYTE_W]) found = 0;
				end
				if (found) begin
					if (hits != '1) hits++;
					if (total != '1) total++;
					blocked = n - 1;
				end
			end
		endfunction

		function void check(logic [LINE_W-1:0] number, logic matched,
			logic [LINE_W-1:0] count, logic [TOTAL_W-1:0] tot);
			line_result_t want;
			if (due.size() == 0) begin
				$error("line result with no line pending: line_number %0d", number);
				errors++;
				return;
			end
			want = due.pop_front();
			if (number !== want.number) begin
				$error("line_number: expected %0d, got %0d", want.number, number);
				errors++;
			end
			if (matched !== want.matched) begin
				$error("line_matched: expected %0d, got %0d", want.matched, matched);
				errors++;
			end
			if (count !== want.count) begin
				$error("line_count: expected %0d, got %0d", want.count, count);
				errors++;
			end
			if (tot !== want.total) begin
				$error("total_count: expected %0d, got %0d", want.total, tot);
				errors++;
			end
		endfunction
	endclass

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    char_byte    = '0;
	logic                 line_end     = 1'b0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [LINE_W-1:0]    line_number;
	logic                 line_matched;
	logic [LINE_W-1:0]    line_count;
	logic [TOTAL_W-1:0]   total_count;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_PATTERN;
	logic [PAT_W-1:0]     cfg_data     = '0;

	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	line_score score;

	line_substring_match_counter_core #(
		.MAX_PATTERN(MAX_LEN)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_byte   (char_byte),
		.line_end    (line_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.line_number (line_number),
		.line_matched(line_matched),
		.line_count  (line_count),
		.total_count (total_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("line_substring_match_counter_core_tb: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			score.check(line_number, line_matched, line_count, total_count);
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_item(byte_t c, logic e);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		char_byte <= c;
		line_end  <= e;
		do @(posedge clk); while (!in_ready);
		score.take(c, e);
	endtask

	task automatic idle_wait();
		in_valid <= 1'b0;
		while (score.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [PAT_W-1:0] pattern, logic [LEN_W-1:0] length);
		logic [PAT_W-1:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = length;
		idle_wait();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_PATTERN;
		cfg_data  <= pattern;
		do @(posedge clk); while (!cfg_ready);
		score.configure(CFG_PATTERN, pattern);
		cfg_index <= CFG_LENGTH;
		cfg_data  <= len_word;
		do @(posedge clk); while (!cfg_ready);
		score.configure(CFG_LENGTH, len_word);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int items);
		int    sent;
		int    n;
		int    r;
		int    cut;
		int    bad;
		byte_t c;
		sent = 0;
		while (sent < items) begin
			n = score.span();
			r = $urandom_range(99);
			if (r < 9) begin
				send_item(byte_t'($urandom), 1'b1);
				sent++;
			end else if (r < 50) begin
				// insert the pattern, sometimes cut short or with one byte corrupted
				cut = n;
				if ($urandom_range(9) == 0) cut = $urandom_range(n);
				bad = ($urandom_range(9) == 0) ? int'($urandom_range(n - 1)) : -1;
				for (int k = 0; k < cut; k++) begin
					c = score.pattern[BYTE_W*k +: BYTE_W];
					if (k == bad) c = byte_t'($urandom);
					send_item(c, 1'b0);
					sent++;
				end
			end else if (r < 85) begin
				send_item(score.pattern[BYTE_W*$urandom_range(n - 1) +: BYTE_W], 1'b0);
				sent++;
			end else begin
				send_item(byte_t'($urandom), 1'b0);
				sent++;
			end
		end
	endtask

	initial begin
		int               lens[12] = '{1, 8, 0, 15, 2, 4, 9, 3, 5, 6, 7, 8};
		logic [PAT_W-1:0] pat;
		score = new();
		score.clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'h5a, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hff, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hc3, 1'b1);
		pat = {$urandom, $urandom};
		pat[23:0] = 24'h616161;
		set_config(pat, 3);
		repeat (7) send_item(8'h61, 1'b0);
		send_item(8'h3c, 1'b1);
		repeat (2) send_item(8'h61, 1'b0);
		set_config(pat, 2);
		send_item(8'h61, 1'b0);
		send_item(8'h00, 1'b1);
		set_config('1, 8);
		repeat (8) send_item(8'hff, 1'b0);
		send_item(8'hff, 1'b1);

		for (int p = 0; p < 12; p++) begin
			pat = {$urandom, $urandom};
			case (p)
				4, 11: pat = {8{pat[7:0]}};
				5:     pat = {4{pat[15:0]}};
				8:     pat = '1;
				9:     pat = '0;
				default: ;
			endcase
			set_config(pat, LEN_W'(lens[p]));
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 66;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 66;
				end
				default: begin
					send_idle_pct  = 29;
					recv_stall_pct = 29;
				end
			endcase
			run_random(130);
		end

		in_valid <= 1'b0;
		for (int w = 0; w < 10000 && score.pending() != 0; w++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (score.pending() != 0) begin
			$error("%0d line results never arrived", score.pending());
			score.errors++;
		end
		if (score.errors == 0) begin
			$display("line_substring_match_counter_core_tb: clean");
		end else begin
			$display("line_substring_match_counter_core_tb: errors");
		end
		$finish;
	end

endmodule

### line_substring_match_counter_core.f
src/lsmc_pkg.sv
src/lsmc_cell.sv
src/line_substring_match_counter_core.sv
verif/line_substring_match_counter_core_tb.sv
